FILE: rtl/cssg_pkg.sv
package cssg_pkg;

  // fixed field widths
  localparam int RADIUS_BITS = 6;
  localparam int WIDTH_BITS  = 7;
  localparam int SCREEN_BITS = 12;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;

  // defaults for the top-level parameters
  localparam int DEF_MAX_RADIUS = 63;
  localparam int DEF_COORD_BITS = 12;

  // register reset values
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_WIDTH  = SCREEN_BITS'(640);
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_HEIGHT = SCREEN_BITS'(480);

  // apb register map, index = paddr[3:2]
  localparam int APB_ADDR_BITS = 4;
  typedef enum logic [1:0] {
    REG_CLIP_ENABLE   = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } reg_index_t;

  // one square-root iteration per result bit
  localparam int SQRT_STEPS = RADIUS_BITS;
  localparam int ITER_BITS  = $clog2(SQRT_STEPS + 1);

  // microprogram
  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_LOAD   = 3'd0;
  localparam step_t STEP_RSQ    = 3'd1;
  localparam step_t STEP_KSQ    = 3'd2;
  localparam step_t STEP_NDIFF  = 3'd3;
  localparam step_t STEP_SQRT   = 3'd4;
  localparam step_t STEP_ROUND  = 3'd5;
  localparam step_t STEP_ROW    = 3'd6;
  localparam step_t STEP_CENTER = 3'd7;

  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_RSQ,
    ACT_KSQ,
    ACT_NDIFF,
    ACT_SQRT,
    ACT_ROUND,
    ACT_EMIT_ROW,
    ACT_EMIT_CENTER
  } action_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_OUTPUT
  } wait_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_K_ZERO,
    JMP_K_MORE,
    JMP_ITER_MORE
  } cond_t;

  typedef struct packed {
    action_t act;
    wait_t   hold;
    cond_t   cond;
    step_t   target;
  } ctrl_word_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    unique case (step)
      STEP_LOAD:   w = '{ACT_LOAD,        WAIT_INPUT,  JMP_NEVER,     STEP_LOAD};
      STEP_RSQ:    w = '{ACT_RSQ,         WAIT_NONE,   JMP_K_ZERO,    STEP_CENTER};
      STEP_KSQ:    w = '{ACT_KSQ,         WAIT_NONE,   JMP_NEVER,     STEP_LOAD};
      STEP_NDIFF:  w = '{ACT_NDIFF,       WAIT_NONE,   JMP_NEVER,     STEP_LOAD};
      STEP_SQRT:   w = '{ACT_SQRT,        WAIT_NONE,   JMP_ITER_MORE, STEP_SQRT};
      STEP_ROUND:  w = '{ACT_ROUND,       WAIT_NONE,   JMP_NEVER,     STEP_LOAD};
      STEP_ROW:    w = '{ACT_EMIT_ROW,    WAIT_OUTPUT, JMP_K_MORE,    STEP_KSQ};
      STEP_CENTER: w = '{ACT_EMIT_CENTER, WAIT_OUTPUT, JMP_ALWAYS,    STEP_LOAD};
      default:     w = '{ACT_LOAD,        WAIT_INPUT,  JMP_NEVER,     STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/cssg_if.sv
interface cssg_circle_if #(
  parameter int COORD_BITS = cssg_pkg::DEF_COORD_BITS
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        center_x;
  logic signed [COORD_BITS-1:0]        center_y;
  logic [cssg_pkg::RADIUS_BITS-1:0]    circle_radius;

  modport source (output valid, center_x, center_y, circle_radius, input ready);
  modport sink   (input valid, center_x, center_y, circle_radius, output ready);
endinterface

interface cssg_span_if #(
  parameter int COORD_BITS = cssg_pkg::DEF_COORD_BITS
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS:0]          span_x;
  logic [cssg_pkg::WIDTH_BITS-1:0]     span_width;
  logic signed [COORD_BITS:0]          upper_row;
  logic                                upper_visible;
  logic signed [COORD_BITS:0]          lower_row;
  logic                                lower_visible;
  logic                                last_span;

  modport source (output valid, span_x, span_width, upper_row, upper_visible,
                  lower_row, lower_visible, last_span, input ready);
  modport sink   (input valid, span_x, span_width, upper_row, upper_visible,
                  lower_row, lower_visible, last_span, output ready);
endinterface

FILE: rtl/circle_scanline_span_generator.sv
// channel   dir   transfer moves                     handshake
// --------  ----  ---------------------------------  ------------------------
// circle    in    center_x, center_y, circle_radius  valid & ready
// span      out   span_x, span_width, rows, flags    valid & ready
// apb       in    clip_enable, screen size regs      psel & penable & pwrite
//
// for each row pair of a circle the microprogram runs square, subtract,
// 6 square-root iterations, round and emit, using the shared
// one-bit-per-cycle square-root unit.
// radius zero yields only the center row.
// rst is synchronous and active high; it returns the sequencer to its load
// step and empties the output register.
// the emit steps hold while the output register is full and not drained;
// a new circle is taken while the last span of the previous one still waits.
module circle_scanline_span_generator #(
  parameter int MAX_RADIUS = cssg_pkg::DEF_MAX_RADIUS,
  parameter int COORD_BITS = cssg_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  cssg_circle_if.sink                         circle,
  cssg_span_if.source                         span,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cssg_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int RB = cssg_pkg::RADIUS_BITS;
  localparam int WB = cssg_pkg::WIDTH_BITS;
  localparam int SB = cssg_pkg::SCREEN_BITS;
  localparam int QB = cssg_pkg::SQ_BITS;
  localparam int IB = cssg_pkg::ITER_BITS;
  localparam int OW = COORD_BITS + 1;
  // clip arithmetic width: holds span ends and an unsigned screen size
  localparam int CW = (OW + 1 > SB + 2) ? OW + 1 : SB + 2;
  localparam logic [RB-1:0] R_MAX = RB'(MAX_RADIUS);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic          clip_enable;
  logic [SB-1:0] disp_width;
  logic [SB-1:0] disp_height;
  logic [1:0]    reg_sel;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b0;
      disp_width  <= cssg_pkg::RST_SCREEN_WIDTH;
      disp_height <= cssg_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_write) begin
      case (reg_sel)
        cssg_pkg::REG_CLIP_ENABLE:   clip_enable <= pwdata[0];
        cssg_pkg::REG_SCREEN_WIDTH:  disp_width  <= pwdata[SB-1:0];
        cssg_pkg::REG_SCREEN_HEIGHT: disp_height <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cssg_pkg::REG_CLIP_ENABLE:   prdata = {31'd0, clip_enable};
      cssg_pkg::REG_SCREEN_WIDTH:  prdata = {{(32-SB){1'b0}}, disp_width};
      cssg_pkg::REG_SCREEN_HEIGHT: prdata = {{(32-SB){1'b0}}, disp_height};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  cssg_pkg::step_t      pc;
  cssg_pkg::step_t      pc_next;
  cssg_pkg::ctrl_word_t cw;
  logic                 out_free;
  logic                 held;
  logic                 jump;

  // datapath registers
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [RB-1:0]                r;
  logic [RB-1:0]                k;
  logic [QB-1:0]                rsq;
  logic [QB-1:0]                ksq;
  logic [QB-1:0]                n_sh;     // radicand, shifted out two bits a step
  logic [RB:0]                  rem;      // partial remainder, stays below 2*root+1
  logic [RB-1:0]                root;
  logic [RB-1:0]                h;
  logic [IB-1:0]                iter;

  // output register
  logic                 out_valid;
  logic signed [OW-1:0] out_x;
  logic [WB-1:0]        out_w;
  logic signed [OW-1:0] out_up;
  logic                 out_upv;
  logic signed [OW-1:0] out_lo;
  logic                 out_lov;
  logic                 out_last;
  logic                 out_load;

  assign cw       = cssg_pkg::ucode(pc);
  assign out_free = !out_valid || span.ready;

  always_comb begin
    unique case (cw.hold)
      cssg_pkg::WAIT_INPUT:  held = !circle.valid;
      cssg_pkg::WAIT_OUTPUT: held = !out_free;
      default:               held = 1'b0;
    endcase
  end

  // conditions look at register values before this step updates them
  always_comb begin
    unique case (cw.cond)
      cssg_pkg::JMP_ALWAYS:    jump = 1'b1;
      cssg_pkg::JMP_K_ZERO:    jump = (k == '0);
      cssg_pkg::JMP_K_MORE:    jump = (k != RB'(1));
      cssg_pkg::JMP_ITER_MORE: jump = (iter != IB'(1));
      default:                 jump = 1'b0;
    endcase
  end

  always_comb begin
    if (held) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + cssg_pkg::step_t'(1);
    end
  end

  // no circle is taken while reset holds the sequencer
  assign circle.ready = !rst && (cw.act == cssg_pkg::ACT_LOAD);
  assign out_load     = !held &&
                        (cw.act == cssg_pkg::ACT_EMIT_ROW || cw.act == cssg_pkg::ACT_EMIT_CENTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cssg_pkg::STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------------
  // square-root step: restoring, one root bit per cycle
  // ---------------------------------------------------------------------
  logic [RB+2:0] rem_sh;
  logic [RB+2:0] trial;
  logic          take;

  assign rem_sh = {rem, n_sh[QB-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = (rem_sh >= trial);

  // radius saturation on the way in
  logic [RB-1:0] r_in;
  assign r_in = (circle.circle_radius > R_MAX) ? R_MAX : circle.circle_radius;

  always_ff @(posedge clk) begin
    if (!held) begin
      unique case (cw.act)
        cssg_pkg::ACT_LOAD: begin
          cx <= circle.center_x;
          cy <= circle.center_y;
          r  <= r_in;
          k  <= r_in;
        end
        cssg_pkg::ACT_RSQ:   rsq <= QB'(r) * QB'(r);
        cssg_pkg::ACT_KSQ:   ksq <= QB'(k) * QB'(k);
        cssg_pkg::ACT_NDIFF: begin
          n_sh <= rsq - ksq;
          rem  <= '0;
          root <= '0;
          iter <= IB'(cssg_pkg::SQRT_STEPS);
        end
        cssg_pkg::ACT_SQRT: begin
          n_sh <= {n_sh[QB-3:0], 2'b00};
          rem  <= take ? (RB+1)'(rem_sh - trial) : rem_sh[RB:0];
          root <= {root[RB-2:0], take};
          iter <= iter - IB'(1);
        end
        // round to nearest: n - s*s > s adds one
        cssg_pkg::ACT_ROUND:    h <= root + RB'(rem > {1'b0, root});
        cssg_pkg::ACT_EMIT_ROW: k <= k - RB'(1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // span formation and clipping
  // ---------------------------------------------------------------------
  logic                 is_center;
  logic [RB-1:0]        h_eff;
  logic [OW-1:0]        h_ext;
  logic [OW-1:0]        k_ext;
  logic signed [OW-1:0] raw_x;
  logic [WB-1:0]        raw_w;
  logic signed [OW-1:0] raw_up;
  logic signed [OW-1:0] raw_lo;

  assign is_center = (cw.act == cssg_pkg::ACT_EMIT_CENTER);
  assign h_eff     = is_center ? r : h;
  assign h_ext     = {{(OW-RB){1'b0}}, h_eff};
  assign k_ext     = is_center ? '0 : {{(OW-RB){1'b0}}, k};
  assign raw_x     = {cx[COORD_BITS-1], cx} - h_ext;
  assign raw_w     = {h_eff, 1'b0};
  assign raw_up    = {cy[COORD_BITS-1], cy} - k_ext;
  assign raw_lo    = {cy[COORD_BITS-1], cy} + k_ext;

  logic signed [CW-1:0] x_c;
  logic signed [CW-1:0] end_raw;
  logic signed [CW-1:0] start_c;
  logic signed [CW-1:0] end_c;
  logic signed [CW-1:0] sw_c;
  logic signed [CW-1:0] sh_c;
  logic signed [CW-1:0] up_c;
  logic signed [CW-1:0] lo_c;
  logic signed [CW-1:0] len_c;
  logic signed [OW-1:0] clip_x;
  logic [WB-1:0]        clip_w;
  logic                 clip_upv;
  logic                 clip_lov;

  assign x_c     = {{(CW-OW){raw_x[OW-1]}}, raw_x};
  assign up_c    = {{(CW-OW){raw_up[OW-1]}}, raw_up};
  assign lo_c    = {{(CW-OW){raw_lo[OW-1]}}, raw_lo};
  assign sw_c    = {{(CW-SB){1'b0}}, disp_width};
  assign sh_c    = {{(CW-SB){1'b0}}, disp_height};
  assign end_raw = x_c + {{(CW-WB){1'b0}}, raw_w};
  assign start_c = x_c[CW-1] ? '0 : x_c;
  assign end_c   = (end_raw > sw_c) ? sw_c : end_raw;
  assign len_c   = end_c - start_c;

  always_comb begin
    if (end_c <= start_c) begin
      // span wholly off screen
      clip_x = '0;
      clip_w = '0;
    end else begin
      clip_x = start_c[OW-1:0];
      clip_w = len_c[WB-1:0];
    end
    clip_upv = (clip_w != '0) && !up_c[CW-1] && (up_c < sh_c);
    clip_lov = (clip_w != '0) && !lo_c[CW-1] && (lo_c < sh_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (span.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= clip_enable ? clip_x : raw_x;
      out_w    <= clip_enable ? clip_w : raw_w;
      out_up   <= raw_up;
      out_lo   <= raw_lo;
      out_upv  <= clip_enable ? clip_upv : 1'b1;
      out_lov  <= clip_enable ? clip_lov : 1'b1;
      out_last <= is_center;
    end
  end

  assign span.valid         = out_valid;
  assign span.span_x        = out_x;
  assign span.span_width    = out_w;
  assign span.upper_row     = out_up;
  assign span.upper_visible = out_upv;
  assign span.lower_row     = out_lo;
  assign span.lower_visible = out_lov;
  assign span.last_span     = out_last;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_accept_then_rsq: assert property (@(posedge clk) disable iff (rst)
    (circle.valid && circle.ready) |=> (pc == cssg_pkg::STEP_RSQ))
    else $error("circle transfer did not advance to the squaring step");

  a_sqrt_exit: assert property (@(posedge clk) disable iff (rst)
    (pc == cssg_pkg::STEP_SQRT && iter == IB'(1)) |=> (pc == cssg_pkg::STEP_ROUND))
    else $error("square-root loop ran the wrong number of iterations");

  a_center_returns: assert property (@(posedge clk) disable iff (rst)
    (pc == cssg_pkg::STEP_CENTER && out_free) |=> (pc == cssg_pkg::STEP_LOAD && out_last))
    else $error("center row did not close the circle");

  a_clip_visible: assert property (@(posedge clk) disable iff (rst)
    (out_load && clip_enable) |=>
      !((out_upv || out_lov) && out_w == '0))
    else $error("clipped span marked visible with zero width");

endmodule

FILE: sim/tb_circle_scanline_span_generator.sv
`timescale 1ns / 100ps

module tb_circle_scanline_span_generator;

  localparam int CB            = cssg_pkg::DEF_COORD_BITS;
  localparam int RW            = CB + 1;
  localparam int MAX_R         = cssg_pkg::DEF_MAX_RADIUS;
  localparam int RADIUS_BITS   = cssg_pkg::RADIUS_BITS;
  localparam int WIDTH_BITS    = cssg_pkg::WIDTH_BITS;
  localparam int APB_ADDR_BITS = cssg_pkg::APB_ADDR_BITS;
  localparam int COORD_MAX     = (1 << (CB - 1)) - 1;
  localparam int COORD_MIN     = -(1 << (CB - 1));
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 60;
  localparam int PRINT_CAP     = 40;
  localparam int HOLD_PHASE    = 0;
  localparam int DRAIN_PHASE   = 3;

  // one span transfer, laid out like the output channel
  typedef struct packed {
    logic signed [RW-1:0]   x;
    logic [WIDTH_BITS-1:0]  width;
    logic signed [RW-1:0]   up_row;
    logic                   up_vis;
    logic signed [RW-1:0]   lo_row;
    logic                   lo_vis;
    logic                   last;
  } span_t;

  // directed circle; typed rows carry the single center-row span by hand
  typedef struct packed {
    bit clip;
    int cx;
    int cy;
    int r;
    bit typed;
    int x;
    int w;
    bit vis;
  } probe_t;

  // one register setting and the random circles sent under it
  typedef struct packed {
    bit clip;
    bit rand_size;
    int w;
    int h;
    int items;
    int odds;
  } plan_t;

  localparam probe_t PROBES [21] = '{
    // reset setting: clipping off, spans pass through raw
    '{1'b0,     0,     0,  0, 1'b1,     0, 0, 1'b1},  // radius zero gives only the center row
    '{1'b0,  2047,  2047,  0, 1'b1,  2047, 0, 1'b1},  // most positive center
    '{1'b0, -2048, -2048,  0, 1'b1, -2048, 0, 1'b1},  // most negative center
    '{1'b0,   100,   100,  1, 1'b0,     0, 0, 1'b0},
    '{1'b0,     0,     0,  5, 1'b0,     0, 0, 1'b0},
    '{1'b0, -2048, -2048, 63, 1'b0,     0, 0, 1'b0},  // span start runs below the coordinate range
    '{1'b0,  2047,  2047, 63, 1'b0,     0, 0, 1'b0},  // rows run above the coordinate range
    '{1'b0,   320,   240, 63, 1'b0,     0, 0, 1'b0},  // largest radius
    // clipping on, reset screen size
    '{1'b1,     0,     0,  0, 1'b1,     0, 0, 1'b0},  // empty span is never visible
    '{1'b1,    -5,    10,  0, 1'b1,     0, 0, 1'b0},
    '{1'b1,   639,   479,  0, 1'b1,     0, 0, 1'b0},
    '{1'b1,   320,   240, 10, 1'b0,     0, 0, 1'b0},  // wholly inside
    '{1'b1,     0,     0, 10, 1'b0,     0, 0, 1'b0},  // cut at top-left corner
    '{1'b1,   639,   479, 10, 1'b0,     0, 0, 1'b0},  // cut at bottom-right corner
    '{1'b1,   -20,   240, 10, 1'b0,     0, 0, 1'b0},  // mostly off the left side
    '{1'b1,   660,   240, 10, 1'b0,     0, 0, 1'b0},  // mostly off the right side
    '{1'b1,   320,    -5, 10, 1'b0,     0, 0, 1'b0},  // upper rows above the screen
    '{1'b1,   320,   485, 10, 1'b0,     0, 0, 1'b0},  // center row below the screen
    '{1'b1,  2047,  2047, 63, 1'b0,     0, 0, 1'b0},  // wholly off screen
    '{1'b1, -2048, -2048, 63, 1'b0,     0, 0, 1'b0},
    '{1'b1,   320,   240, 63, 1'b0,     0, 0, 1'b0}
  };

  localparam plan_t PLAN [9] = '{
    '{1'b1, 1'b0,  640,  480, 25, 4},  // receiver hold-off at the start
    '{1'b1, 1'b0,    1,    1, 15, 3},  // single-pixel screen
    '{1'b1, 1'b0, 2048, 2048, 25, 0},  // largest screen, no idling
    '{1'b1, 1'b1,    0,    0, 30, 4},  // random screen, sender drains halfway
    '{1'b0, 1'b1,    0,    0, 25, 5},  // clipping off again
    '{1'b1, 1'b0,    0,    0, 10, 3},  // zero screen, every span invisible
    '{1'b1, 1'b0, 4095, 4095, 15, 4},  // size registers past the screen range
    '{1'b1, 1'b1,    0,    0, 30, 2},  // random screen, heavy idling
    '{1'b1, 1'b0,  640,  480, 25, 0}   // closing stretch with no idling
  };

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  cssg_circle_if #(.COORD_BITS(CB)) circle_if ();
  cssg_span_if   #(.COORD_BITS(CB)) span_if ();

  circle_scanline_span_generator #(
    .MAX_RADIUS (MAX_R),
    .COORD_BITS (CB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .circle  (circle_if),
    .span    (span_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // spans still owed by the block, oldest first
  span_t span_expect_q [$];

  // register shadow, starts at the reset values
  bit clip_on = 1'b0;
  int scr_w   = 640;
  int scr_h   = 480;

  int     idle_odds     = 4;  // 1 in idle_odds transfers is followed by a gap; 0 = none
  bit     hold_request  = 1'b0;
  int     hold_left     = 0;
  int     stall_left    = 0;
  int     error_count   = 0;
  int     circles_sent  = 0;
  int     spans_checked = 0;
  int     settings_used = 1;
  longint cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // span predictor
  // ---------------------------------------------------------------------------

  // integer square root rounded to nearest; integer n never sits on a tie
  function automatic int round_half_width(input int n);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= n) s++;
    if (n - s * s > s) s++;
    return s;
  endfunction

  // clip one raw span against the screen shadow and pack it
  function automatic span_t clip_span(input int x0, input int w, input int up, input int lo,
                                      input bit last);
    span_t s;
    int    start;
    int    stop;
    bit    upv;
    bit    lov;
    upv = 1'b1;
    lov = 1'b1;
    if (clip_on) begin
      start = (x0 < 0) ? 0 : x0;
      stop  = x0 + w;
      if (stop > scr_w) stop = scr_w;
      // nothing left on screen: collapse to an empty span at column zero
      if (stop <= start) begin
        x0 = 0;
        w  = 0;
      end else begin
        x0 = start;
        w  = stop - start;
      end
      upv = (w != 0) && (up >= 0) && (up < scr_h);
      lov = (w != 0) && (lo >= 0) && (lo < scr_h);
    end
    s.x      = RW'(x0);
    s.width  = WIDTH_BITS'(w);
    s.up_row = RW'(up);
    s.up_vis = upv;
    s.lo_row = RW'(lo);
    s.lo_vis = lov;
    s.last   = last;
    return s;
  endfunction

  // all spans of one circle: row pairs from the top down, then the center row
  function automatic void predict_circle(input logic signed [CB-1:0] cx,
                                         input logic signed [CB-1:0] cy,
                                         input logic [RADIUS_BITS-1:0] r);
    int x;
    int y;
    int rad;
    int h;
    x   = cx;
    y   = cy;
    rad = r;
    if (rad > MAX_R) rad = MAX_R;
    for (int k = rad; k >= 1; k--) begin
      h = round_half_width(rad * rad - k * k);
      span_expect_q.push_back(clip_span(x - h, 2 * h, y - k, y + k, 1'b0));
    end
    span_expect_q.push_back(clip_span(x - rad, 2 * rad, y, y, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // random fields
  // ---------------------------------------------------------------------------

  // mix of full-range values, values around the low edge and the high edge,
  // and values on the screen
  function automatic logic signed [CB-1:0] rand_coord(input int size);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 4095)) - 2048;
      3, 4:    v = int'($urandom_range(0, 140)) - 70;
      5:       v = size + int'($urandom_range(0, 140)) - 70;
      default: v = (size > 0) ? int'($urandom_range(0, size - 1)) : 0;
    endcase
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return CB'(v);
  endfunction

  // small radii mostly; big circles are slow
  function automatic logic [RADIUS_BITS-1:0] rand_radius();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return RADIUS_BITS'($urandom_range(0, 8));
      6, 7, 8:          return RADIUS_BITS'($urandom_range(9, 31));
      default:          return RADIUS_BITS'($urandom_range(32, 63));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input cssg_pkg::reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input bit clip, input int w, input int h);
    write_reg(cssg_pkg::REG_CLIP_ENABLE, 32'(clip));
    write_reg(cssg_pkg::REG_SCREEN_WIDTH, 32'(w));
    write_reg(cssg_pkg::REG_SCREEN_HEIGHT, 32'(h));
    clip_on = clip;
    scr_w   = w;
    scr_h   = h;
    settings_used++;
  endtask

  // drop valid and hold off until every owed span has come out
  task automatic wait_drained();
    @(negedge clk);
    circle_if.valid <= 1'b0;
    while (span_expect_q.size() != 0) @(posedge clk);
  endtask

  // offer one circle, with an occasional gap first; predict on transfer
  task automatic send_circle(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                             input logic [RADIUS_BITS-1:0] r, input bit typed,
                             input span_t typed_span);
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      circle_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    circle_if.valid         <= 1'b1;
    circle_if.center_x      <= cx;
    circle_if.center_y      <= cy;
    circle_if.circle_radius <= r;
    do @(posedge clk); while (!circle_if.ready);
    circles_sent++;
    if (typed) span_expect_q.push_back(typed_span);
    else predict_circle(cx, cy, r);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string field_msg(input string name, input int got, input int want);
    return $sformatf("span %0d %s got %0d want %0d", spans_checked, name, got, want);
  endfunction

  task automatic check_span(input span_t got);
    span_t want;
    if (span_expect_q.size() == 0) begin
      report_mismatch($sformatf("span with none owed: x %0d row %0d last %0b",
                                got.x, got.up_row, got.last));
      return;
    end
    want = span_expect_q.pop_front();
    spans_checked++;
    if (got.x !== want.x)           report_mismatch(field_msg("span_x", got.x, want.x));
    if (got.width !== want.width)   report_mismatch(field_msg("span_width", got.width,
                                                              want.width));
    if (got.up_row !== want.up_row) report_mismatch(field_msg("upper_row", got.up_row,
                                                              want.up_row));
    if (got.up_vis !== want.up_vis) report_mismatch(field_msg("upper_visible", got.up_vis,
                                                              want.up_vis));
    if (got.lo_row !== want.lo_row) report_mismatch(field_msg("lower_row", got.lo_row,
                                                              want.lo_row));
    if (got.lo_vis !== want.lo_vis) report_mismatch(field_msg("lower_visible", got.lo_vis,
                                                              want.lo_vis));
    if (got.last !== want.last)     report_mismatch(field_msg("last_span", got.last,
                                                              want.last));
  endtask

  // every span transfer is checked against the oldest owed span
  always @(posedge clk) begin
    if (!rst && span_if.valid && span_if.ready)
      check_span({span_if.span_x, span_if.span_width, span_if.upper_row,
                  span_if.upper_visible, span_if.lower_row, span_if.lower_visible,
                  span_if.last_span});
  end

  // span receiver: random stall bursts, plus one long hold-off on request
  // that lets the output register fill and the block back up its input
  initial begin
    span_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        span_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        span_if.ready <= 1'b0;
      end else begin
        span_if.ready <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          stall_left = $urandom_range(1, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spans still owed", cycle_count,
               span_expect_q.size());
      $display("circle_scanline_span_generator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int     w;
    int     h;
    plan_t  plan;
    probe_t row;
    span_t  hand_span;

    // every block input known from time zero
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    circle_if.valid         = 1'b0;
    circle_if.center_x      = '0;
    circle_if.center_y      = '0;
    circle_if.circle_radius = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; the first rows run on the reset register values
    foreach (PROBES[i]) begin
      row = PROBES[i];
      if (row.clip != clip_on) begin
        wait_drained();
        apply_setting(row.clip, 640, 480);
      end
      hand_span = {RW'(row.x), WIDTH_BITS'(row.w), RW'(row.cy), row.vis, RW'(row.cy),
                   row.vis, 1'b1};
      send_circle(CB'(row.cx), CB'(row.cy), RADIUS_BITS'(row.r), row.typed, hand_span);
    end

    // random circles under a series of register settings
    foreach (PLAN[p]) begin
      plan = PLAN[p];
      w = plan.rand_size ? int'($urandom_range(1, 2048)) : plan.w;
      h = plan.rand_size ? int'($urandom_range(1, 2048)) : plan.h;
      wait_drained();
      apply_setting(plan.clip, w, h);
      idle_odds = plan.odds;
      if (p == HOLD_PHASE) hold_request = 1'b1;
      for (int n = 0; n < plan.items; n++) begin
        // sender pause until the block has emptied
        if (p == DRAIN_PHASE && n == plan.items / 2) wait_drained();
        send_circle(rand_coord(scr_w), rand_coord(scr_h), rand_radius(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d circles (%0d directed) gave %0d checked spans over %0d register settings",
             circles_sent, $size(PROBES), spans_checked, settings_used);
    $display("clipping on and off, screens from zero to full size, stalls and hold-off");
    if (error_count == 0) begin
      $display("circle_scanline_span_generator verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("circle_scanline_span_generator verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cssg_pkg.sv
rtl/cssg_if.sv
rtl/circle_scanline_span_generator.sv
sim/tb_circle_scanline_span_generator.sv
